// ===== hdl/fmi_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and helpers shared by the field multiply / invert block
// no dependencies

package fmi_pkg;

   localparam int WORD_W = 32;
   localparam int WORDS = 8;
   localparam int FOLD_HIGH = 38;
   localparam int FOLD_TOP = 19;
   localparam int LADDER_TOP = 253;
   localparam logic [7:0] LADDER_FIRST = 8'(LADDER_TOP + 1);
   localparam logic [7:0] LADDER_LAST = 8'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } fmi_state_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  idx;
      logic [31:0] word;
      logic        final_op;
   } fmi_word_type;

   typedef struct packed {
      logic         valid;
      logic         final_op;
      logic [254:0] value;
   } fmi_res_type;

   // bit k of the exponent p - 2
   function automatic logic exp_bit(input logic [7:0] k);
      exp_bit = (k >= 8'd5) || (k == 8'd3) || (k == 8'd1) || (k == 8'd0);
   endfunction

endpackage

// ===== hdl/field_mul_inv_mod_p25519.sv =====
`timescale 1ns / 1ps
// top level: multiply and invert modulo 2^255-19 with a ladder sequencer
// depends on fmi_pkg, fmi_mul_chain, fmi_reduce
//
//   channel   handshake          payload
//   request   start / busy       req_type, req_a_limb0..3, req_b_limb0..3
//   response  rsp_valid strobe   rsp_res_limb0..3
//
// one field multiplication occupies the eight-cell chain (the word rows, then the carry
// flush) and then the reduction; a new multiply is taken once the chain is free, while the
// previous one is still in the reduction
// invert runs 508 dependent multiplications before its result
// reset is synchronous and clears the sequencer, the chain and the strobe pipeline
// the receiver cannot stall; each result is shown for one cycle

module field_mul_inv_mod_p25519 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [63:0] req_a_limb0,
   input  logic [63:0] req_a_limb1,
   input  logic [63:0] req_a_limb2,
   input  logic [63:0] req_a_limb3,
   input  logic [63:0] req_b_limb0,
   input  logic [63:0] req_b_limb1,
   input  logic [63:0] req_b_limb2,
   input  logic [63:0] req_b_limb3,
   output logic        rsp_valid,
   output logic [63:0] rsp_res_limb0,
   output logic [63:0] rsp_res_limb1,
   output logic [63:0] rsp_res_limb2,
   output logic [62:0] rsp_res_limb3
);
   import fmi_pkg::*;

   fmi_state_type state_ff;
   fmi_state_type state_in;
   logic [7:0]   k_ff;
   logic         ph_ff;
   logic [255:0] r0_ff;
   logic [255:0] r1_ff;

   logic         chain_busy;
   logic         chain_start;
   logic [255:0] chain_x;
   logic [255:0] chain_y;
   logic         chain_final;
   fmi_word_type word;
   fmi_res_type  res;
   logic         accept;
   logic         bit_k;
   logic         step_done;
   logic [255:0] a_vec;
   logic [255:0] b_vec;

   assign a_vec = {req_a_limb3, req_a_limb2, req_a_limb1, req_a_limb0};
   assign b_vec = {req_b_limb3, req_b_limb2, req_b_limb1, req_b_limb0};
   assign busy = (state_ff != ST_IDLE) || chain_busy;
   assign accept = start && !busy;
   assign bit_k = exp_bit(k_ff);
   assign step_done = res.valid && !res.final_op;

   always_comb begin
      state_in = state_ff;
      chain_start = 1'b0;
      chain_x = r0_ff;
      chain_y = r1_ff;
      chain_final = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type) begin
                  state_in = ST_ISSUE;
               end else begin
                  chain_start = 1'b1;
                  chain_x = a_vec;
                  chain_y = b_vec;
                  chain_final = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            chain_start = 1'b1;
            if (k_ff == LADDER_FIRST) begin
               chain_y = r0_ff;
            end else if (k_ff != LADDER_LAST && ph_ff) begin
               if (bit_k) begin
                  chain_x = r1_ff;
               end else begin
                  chain_y = r0_ff;
               end
            end
            if (k_ff == LADDER_LAST) begin
               chain_final = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (step_done) begin
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept && req_type) begin
         r0_ff <= a_vec;
         k_ff <= LADDER_FIRST;
         ph_ff <= 1'b0;
      end else if (state_ff == ST_WAIT && step_done) begin
         if (k_ff == LADDER_FIRST) begin
            r1_ff <= {1'b0, res.value};
            k_ff <= k_ff - 8'd1;
            ph_ff <= 1'b0;
         end else begin
            if (ph_ff == bit_k) begin
               r1_ff <= {1'b0, res.value};
            end else begin
               r0_ff <= {1'b0, res.value};
            end
            ph_ff <= !ph_ff;
            if (ph_ff) begin
               k_ff <= k_ff - 8'd1;
            end
         end
      end
   end

   fmi_mul_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .start    (chain_start),
      .x        (chain_x),
      .y        (chain_y),
      .final_op (chain_final),
      .busy     (chain_busy),
      .word_o   (word)
   );

   fmi_reduce u_reduce (
      .clock  (clock),
      .reset  (reset),
      .word_i (word),
      .res_o  (res)
   );

   assign rsp_valid = res.valid && res.final_op;
   assign rsp_res_limb0 = res.value[63:0];
   assign rsp_res_limb1 = res.value[127:64];
   assign rsp_res_limb2 = res.value[191:128];
   assign rsp_res_limb3 = res.value[254:192];

endmodule

// ===== hdl/fmi_cell.sv =====
`timescale 1ns / 1ps
// one cell of the multiplier chain: a 32x32 multiply-accumulate with its own word and carry
// no dependencies

module fmi_cell (
   input  logic        clock,
   input  logic        clear,
   input  logic        enable,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] up,
   output logic [31:0] lo
);

   logic [31:0] s_ff;
   logic [31:0] k_ff;
   logic [63:0] t;

   assign t = {32'b0, x} * {32'b0, y} + {32'b0, s_ff} + {32'b0, k_ff};
   assign lo = t[31:0];

   always_ff @(posedge clock) begin
      if (clear) begin
         s_ff <= '0;
         k_ff <= '0;
      end else if (enable) begin
         s_ff <= up;
         k_ff <= t[63:32];
      end
   end

endmodule

// ===== hdl/fmi_mul_chain.sv =====
`timescale 1ns / 1ps
// eight-cell multiplier chain producing the 512-bit product one word per cycle
// depends on fmi_pkg and fmi_cell

module fmi_mul_chain (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [255:0]        x,
   input  logic [255:0]        y,
   input  logic                final_op,
   output logic                busy,
   output fmi_pkg::fmi_word_type word_o
);
   import fmi_pkg::*;

   logic         active_ff;
   logic [3:0]   cnt_ff;
   logic [255:0] x_sr_ff;
   logic [255:0] y_ff;
   logic         final_ff;
   logic [31:0]  x_word;
   logic [31:0]  lo [WORDS];
   logic [31:0]  up [WORDS];

   assign x_word = cnt_ff[3] ? '0 : x_sr_ff[31:0];
   assign busy = active_ff;

   for (genvar j = 0; j < WORDS; j++) begin : g_cell
      if (j == WORDS - 1) begin : g_top
         assign up[j] = '0;
      end else begin : g_mid
         assign up[j] = lo[j + 1];
      end
      fmi_cell u_cell (
         .clock  (clock),
         .clear  (start),
         .enable (active_ff),
         .x      (x_word),
         .y      (y_ff[WORD_W*j +: WORD_W]),
         .up     (up[j]),
         .lo     (lo[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         active_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_sr_ff <= x;
         y_ff <= y;
         final_ff <= final_op;
      end else if (active_ff) begin
         x_sr_ff <= {32'b0, x_sr_ff[255:32]};
      end
   end

   always_comb begin
      word_o.valid = active_ff;
      word_o.idx = cnt_ff;
      word_o.word = lo[0];
      word_o.final_op = final_ff;
   end

endmodule

// ===== hdl/fmi_reduce.sv =====
`timescale 1ns / 1ps
// reduction mod 2^255-19 of the product word stream: fold by 38, fold top bit, final subtract
// depends on fmi_pkg

module fmi_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  fmi_pkg::fmi_word_type word_i,
   output fmi_pkg::fmi_res_type  res_o
);
   import fmi_pkg::*;

   localparam logic [37:0] HIGH38 = 38'(FOLD_HIGH);
   localparam logic [10:0] HIGH11 = 11'(FOLD_HIGH);
   localparam logic [10:0] TOP11 = 11'(FOLD_TOP);
   localparam logic [255:0] TOP256 = 256'(FOLD_TOP);

   logic [31:0]  low_sr_ff [WORDS];
   logic [31:0]  r_sr_ff [WORDS];
   logic [5:0]   c_ff;
   logic         a_ff;
   logic         a_final_ff;
   logic [255:0] v_ff;
   logic         b_ff;
   logic         b_final_ff;
   logic [254:0] res_ff;
   logic         out_ff;
   logic         out_final_ff;

   logic [5:0]   c_prev;
   logic [37:0]  s;
   logic [255:0] r_vec;
   logic [10:0]  c2;
   logic [255:0] v;
   logic [255:0] alt;

   always_comb begin
      c_prev = (word_i.idx == 4'd8) ? '0 : c_ff;
      s = 38'(c_prev) + 38'(low_sr_ff[0]) + 38'(word_i.word) * HIGH38;
      for (int i = 0; i < WORDS; i++) begin
         r_vec[WORD_W*i +: WORD_W] = r_sr_ff[i];
      end
      c2 = (r_vec[255] ? TOP11 : 11'd0) + 11'(c_ff) * HIGH11;
      v = {1'b0, r_vec[254:0]} + 256'(c2);
      alt = v_ff + TOP256;
   end

   always_ff @(posedge clock) begin
      if (word_i.valid) begin
         for (int i = 0; i < WORDS - 1; i++) begin
            low_sr_ff[i] <= low_sr_ff[i + 1];
         end
         low_sr_ff[WORDS - 1] <= word_i.word;
         if (word_i.idx[3]) begin
            for (int i = 0; i < WORDS - 1; i++) begin
               r_sr_ff[i] <= r_sr_ff[i + 1];
            end
            r_sr_ff[WORDS - 1] <= s[31:0];
            c_ff <= s[37:32];
         end
      end
      if (word_i.valid && word_i.idx == 4'd15) begin
         a_final_ff <= word_i.final_op;
      end
      if (a_ff) begin
         v_ff <= v;
         b_final_ff <= a_final_ff;
      end
      if (b_ff) begin
         res_ff <= alt[255] ? alt[254:0] : v_ff[254:0];
         out_final_ff <= b_final_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 1'b0;
         b_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         a_ff <= word_i.valid && word_i.idx == 4'd15;
         b_ff <= a_ff;
         out_ff <= b_ff;
      end
   end

   always_comb begin
      res_o.valid = out_ff;
      res_o.final_op = out_final_ff;
      res_o.value = res_ff;
   end

endmodule

// ===== hdl/fmi_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the field multiply / invert block, bound to the top level
// depends on field_mul_inv_mod_p25519

module fmi_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [63:0] rsp_res_limb0,
   input logic [63:0] rsp_res_limb1,
   input logic [63:0] rsp_res_limb2,
   input logic [62:0] rsp_res_limb3
);

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_res_limb3 == 63'h7FFF_FFFF_FFFF_FFFF
                      && rsp_res_limb2 == 64'hFFFF_FFFF_FFFF_FFFF
                      && rsp_res_limb1 == 64'hFFFF_FFFF_FFFF_FFFF
                      && rsp_res_limb0 >= 64'hFFFF_FFFF_FFFF_FFED))
      else $error("result not below the modulus");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("strobe or busy after reset");

endmodule

bind field_mul_inv_mod_p25519 fmi_checker u_fmi_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_res_limb0 (rsp_res_limb0),
   .rsp_res_limb1 (rsp_res_limb1),
   .rsp_res_limb2 (rsp_res_limb2),
   .rsp_res_limb3 (rsp_res_limb3)
);

// ===== tb/sv/field_mul_inv_mod_p25519_checker.sv =====
`timescale 1ns / 1ps
// checker for the mod 2^255-19 multiply / invert block: predicts each result and compares
// depends on nothing but the block's port list

module field_mul_inv_mod_p25519_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_type,
   input  logic [63:0] req_a_limb0,
   input  logic [63:0] req_a_limb1,
   input  logic [63:0] req_a_limb2,
   input  logic [63:0] req_a_limb3,
   input  logic [63:0] req_b_limb0,
   input  logic [63:0] req_b_limb1,
   input  logic [63:0] req_b_limb2,
   input  logic [63:0] req_b_limb3,
   input  logic        rsp_valid,
   input  logic [63:0] rsp_res_limb0,
   input  logic [63:0] rsp_res_limb1,
   input  logic [63:0] rsp_res_limb2,
   input  logic [62:0] rsp_res_limb3,
   output int          fail_count,
   output int          pending
);

   localparam logic [255:0] PRIME = (256'd1 << 255) - 256'd19;

   logic [254:0] residue_q[$];

   // product reduced to canonical form
   function automatic logic [254:0] mul_mod(input logic [255:0] x, input logic [255:0] y);
      logic [511:0] prod;
      logic [511:0] folded;
      prod = 512'(x) * 512'(y);
      folded = prod % 512'(PRIME);
      return folded[254:0];
   endfunction

   // fermat inverse by square and multiply over the bits of p - 2
   function automatic logic [254:0] inv_mod(input logic [255:0] x);
      logic [255:0] acc;
      logic [255:0] base;
      logic [255:0] ex;
      acc = 256'd1;
      base = 256'(mul_mod(x, 256'd1));
      ex = PRIME - 256'd2;
      for (int k = 0; k < 255; k++) begin
         if (ex[k]) acc = 256'(mul_mod(acc, base));
         base = 256'(mul_mod(base, base));
      end
      return acc[254:0];
   endfunction

   always @(posedge clock) begin
      logic [255:0] opa;
      logic [255:0] opb;
      logic [254:0] want;
      int           errs;
      errs = 0;
      if (reset) begin
         residue_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (start && !busy) begin
            opa = {req_a_limb3, req_a_limb2, req_a_limb1, req_a_limb0};
            opb = {req_b_limb3, req_b_limb2, req_b_limb1, req_b_limb0};
            residue_q.push_back(req_type ? inv_mod(opa) : mul_mod(opa, opb));
         end
         if (rsp_valid) begin
            if (residue_q.size() == 0) begin
               $error("result with no transaction outstanding");
               errs = errs + 1;
            end else begin
               want = residue_q.pop_front();
               if (rsp_res_limb0 !== want[63:0]) begin
                  $error("res_limb0 exp %h got %h", want[63:0], rsp_res_limb0);
                  errs = errs + 1;
               end
               if (rsp_res_limb1 !== want[127:64]) begin
                  $error("res_limb1 exp %h got %h", want[127:64], rsp_res_limb1);
                  errs = errs + 1;
               end
               if (rsp_res_limb2 !== want[191:128]) begin
                  $error("res_limb2 exp %h got %h", want[191:128], rsp_res_limb2);
                  errs = errs + 1;
               end
               if (rsp_res_limb3 !== want[254:192]) begin
                  $error("res_limb3 exp %h got %h", want[254:192], rsp_res_limb3);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= residue_q.size();
      end
   end

endmodule

// ===== tb/sv/field_mul_inv_mod_p25519_tb.sv =====
`timescale 1ns / 1ps
// testbench top: directed and random multiply / invert transactions with a verdict
// depends on field_mul_inv_mod_p25519 and field_mul_inv_mod_p25519_checker

module field_mul_inv_mod_p25519_tb;

   localparam logic [255:0] PRIME = (256'd1 << 255) - 256'd19;
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_INV = 1'b1;
   localparam int STALL_LIMIT = 60000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = OP_MUL;
   logic [255:0] opa = '0;
   logic [255:0] opb = '0;
   logic        rsp_valid;
   logic [63:0] rsp_res_limb0;
   logic [63:0] rsp_res_limb1;
   logic [63:0] rsp_res_limb2;
   logic [62:0] rsp_res_limb3;
   int          fail_count;
   int          pending;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   field_mul_inv_mod_p25519 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_type(req_type),
      .req_a_limb0(opa[63:0]), .req_a_limb1(opa[127:64]),
      .req_a_limb2(opa[191:128]), .req_a_limb3(opa[255:192]),
      .req_b_limb0(opb[63:0]), .req_b_limb1(opb[127:64]),
      .req_b_limb2(opb[191:128]), .req_b_limb3(opb[255:192]),
      .rsp_valid(rsp_valid), .rsp_res_limb0(rsp_res_limb0), .rsp_res_limb1(rsp_res_limb1),
      .rsp_res_limb2(rsp_res_limb2), .rsp_res_limb3(rsp_res_limb3)
   );

   field_mul_inv_mod_p25519_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_type(req_type),
      .req_a_limb0(opa[63:0]), .req_a_limb1(opa[127:64]),
      .req_a_limb2(opa[191:128]), .req_a_limb3(opa[255:192]),
      .req_b_limb0(opb[63:0]), .req_b_limb1(opb[127:64]),
      .req_b_limb2(opb[191:128]), .req_b_limb3(opb[255:192]),
      .rsp_valid(rsp_valid), .rsp_res_limb0(rsp_res_limb0), .rsp_res_limb1(rsp_res_limb1),
      .rsp_res_limb2(rsp_res_limb2), .rsp_res_limb3(rsp_res_limb3),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** field_mul_inv_mod_p25519: FAILED **");
            $finish;
         end
      end
   end

   function automatic logic [255:0] rand_operand();
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      case ($urandom_range(0, 7))
         0: v = '1;
         1: v = PRIME + 256'($urandom_range(0, 40));
         2: v = 256'($urandom_range(0, 3));
         3: v = PRIME - 256'($urandom_range(1, 3));
         default: ;
      endcase
      return v;
   endfunction

   // one transaction, start held until accepted, an idle gap afterwards on about a third of the calls when asked
   task automatic send(input logic op, input logic [255:0] x, input logic [255:0] y,
                       input bit gaps);
      req_type <= op;
      opa <= x;
      opb <= y;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (gaps && $urandom_range(0, 99) < 34) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   initial begin
      logic [255:0] x;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send(OP_MUL, 256'd0, 256'd0, 1);
      send(OP_MUL, '1, '1, 1);
      send(OP_MUL, PRIME, 256'd5, 1);
      send(OP_MUL, PRIME - 256'd1, PRIME - 256'd1, 1);
      send(OP_MUL, PRIME + 256'd1, '1, 1);
      send(OP_MUL, 256'd1, 256'd1 << 255, 1);
      send(OP_INV, 256'd0, '1, 1);
      send(OP_INV, PRIME, 256'd0, 1);
      send(OP_INV, 256'd1, 256'd7, 1);
      send(OP_INV, '1, 256'd0, 1);
      send(OP_INV, PRIME - 256'd1, '1, 1);
      // drain before continuing
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (int n = 0; n < 100; n++) begin
         x = rand_operand();
         send(($urandom_range(0, 4) == 0) ? OP_INV : OP_MUL, x, rand_operand(),
              (n < 30 || n > 60));
      end
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("** field_mul_inv_mod_p25519: PASSED **");
      end else begin
         $display("** field_mul_inv_mod_p25519: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fmi_pkg.sv
hdl/fmi_cell.sv
hdl/fmi_mul_chain.sv
hdl/fmi_reduce.sv
hdl/field_mul_inv_mod_p25519.sv
hdl/fmi_checker.sv
tb/sv/field_mul_inv_mod_p25519_checker.sv
tb/sv/field_mul_inv_mod_p25519_tb.sv
